@@ design/ac3fcc_pkg.sv @@
// ----------------------------------------------------------------------------
// AC-3 frame CRC checker package
// Word types, the CRC-16 byte table and the byte step shared by the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ac3fcc_pkg;

	// Default upper bound on the word counter.
	localparam int MAX_FRAME_WORDS_DEF = 2048;

	// CRC-16 generator polynomial (x^16 + x^15 + x^2 + 1) and start value.
	localparam logic [15:0] CRC_POLY = 16'h8005;
	localparam logic [15:0] CRC_INIT = 16'h0000;

	// Width used for comparisons between the word index and length terms.
	localparam int CMP_W = 13;

	typedef struct packed {
		logic [15:0] data_word;
		logic [11:0] frame_words;
		logic        last;
	} in_word_t;

	typedef struct packed {
		logic crc1_ok;
		logic crc2_ok;
		logic length_error;
		logic frame_ok;
	} out_word_t;

	typedef logic [15:0] crc_table_t [256];

	// Builds the MSB-first byte table at elaboration time.
	function automatic crc_table_t crc_gen_table();
		crc_table_t  tab;
		logic [15:0] crc;
		for (int i = 0; i < 256; i++) begin
			crc = {8'(i), 8'h00};
			for (int b = 0; b < 8; b++) begin
				if (crc[15]) begin
					crc = {crc[14:0], 1'b0} ^ CRC_POLY;
				end else begin
					crc = {crc[14:0], 1'b0};
				end
			end
			tab[i] = crc;
		end
		return tab;
	endfunction

	localparam crc_table_t CRC_TABLE = crc_gen_table();

	// Advances the CRC register by one byte.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
		logic [7:0] idx;
		idx = crc[15:8] ^ data;
		return {crc[7:0], 8'h00} ^ CRC_TABLE[idx];
	endfunction

endpackage

`default_nettype wire

@@ design/ac3fcc_crc_word.sv @@
// ----------------------------------------------------------------------------
// AC-3 frame CRC word step
// Advances the CRC-16 register by one 16-bit word, high byte first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ac3fcc_crc_word
	import ac3fcc_pkg::*;
(
	input  wire logic [15:0] crc_in,
	input  wire logic [15:0] data,
	output logic      [15:0] crc_out
);

	logic [15:0] crc_mid;

	// Two table look-ups in series, one per byte of the word.
	assign crc_mid = crc_byte(crc_in, data[15:8]);
	assign crc_out = crc_byte(crc_mid, data[7:0]);

endmodule

`default_nettype wire

@@ design/ac3_frame_crc_checker.sv @@
// ----------------------------------------------------------------------------
// AC-3 syncframe CRC checker
// Checks CRC1 and CRC2 of a syncframe delivered as 16-bit words and reports
// one verdict word per frame.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                   Word contents
//  word      in         word_valid / word_ready     data_word, frame_words, last
//  result    out        result_valid / result_ready crc1_ok, crc2_ok,
//                                                   length_error, frame_ok
//
// Each input word is taken into an input register, goes through combinational
// logic (two CRC table look-ups plus the index and length compares) and, on
// the word carrying the last mark, leaves a verdict in the result register.
// The sustained rate is one word per clock. Words that are not the last one
// never wait on the result side, so a stalled result only holds the pipeline
// once a last word reaches it. The asynchronous reset clears the frame state,
// the running CRC and both valid flags; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ac3_frame_crc_checker
	import ac3fcc_pkg::*;
#(
	parameter int MAX_FRAME_WORDS = MAX_FRAME_WORDS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      word_valid,
	output logic           word_ready,
	input  wire in_word_t  word,
	output logic           result_valid,
	input  wire logic      result_ready,
	output out_word_t      result
);

	localparam int IW = $clog2(MAX_FRAME_WORDS);
	localparam logic [IW-1:0] IDX_MAX = IW'(MAX_FRAME_WORDS - 1);

	// Input register.
	logic     valid_s1;
	in_word_t word_s1;

	// Frame state.
	logic [15:0]   crc_q;
	logic [IW-1:0] idx_q;
	logic [11:0]   len_q;
	logic          crc1_q;

	// Result register.
	logic      out_valid_q;
	out_word_t out_q;

	logic        advance;
	logic        first;
	logic [11:0] len_eff;
	logic [15:0] crc_step;
	logic [15:0] crc_new;
	logic [11:0] f58;
	logic        at_crc1;
	logic        crc1_new;
	logic        len_err;
	logic        crc2;

	ac3fcc_crc_word u_crc_word (
		.crc_in  (crc_q),
		.data    (word_s1.data_word),
		.crc_out (crc_step)
	);

	// The staged word moves on unless it is a last word and the result
	// register still holds a verdict that has not been taken.
	assign advance    = valid_s1 && (!word_s1.last || !out_valid_q || result_ready);
	assign word_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (word_ready) begin
			valid_s1 <= word_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (word_ready && word_valid) begin
			word_s1 <= word;
		end
	end

	// Word 0 is the sync word: it only samples the frame length and restarts
	// the CRC, so the running register starts afresh on word 1.
	always_comb begin
		first    = (idx_q == '0);
		len_eff  = first ? word_s1.frame_words : len_q;
		crc_new  = first ? CRC_INIT : crc_step;
		f58      = (len_eff >> 1) + (len_eff >> 3);
		// The CRC1 point is the word at index L/2 + L/8 - 1; an empty span
		// (the sum below two) has no such point and leaves CRC1 passing.
		at_crc1  = (f58 >= 12'd2) && (CMP_W'(idx_q) == CMP_W'(f58) - CMP_W'(1));
		crc1_new = first ? 1'b1 : crc1_q;
		if (at_crc1) begin
			crc1_new = (crc_new == 16'h0000);
		end
		// A zero length can never match, so it always counts as an error.
		len_err = (len_eff == 12'd0) || (CMP_W'(idx_q) != CMP_W'(len_eff) - CMP_W'(1));
		crc2    = (crc_new == 16'h0000);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= CRC_INIT;
			idx_q  <= '0;
			len_q  <= '0;
			crc1_q <= 1'b1;
		end else if (advance) begin
			len_q <= len_eff;
			if (word_s1.last) begin
				crc_q  <= CRC_INIT;
				idx_q  <= '0;
				crc1_q <= 1'b1;
			end else begin
				crc_q  <= crc_new;
				crc1_q <= crc1_new;
				// The index saturates; the CRC keeps running on overlong frames.
				if (idx_q != IDX_MAX) begin
					idx_q <= idx_q + IW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && word_s1.last) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && word_s1.last) begin
			out_q.crc1_ok      <= crc1_new;
			out_q.crc2_ok      <= crc2;
			out_q.length_error <= len_err;
			out_q.frame_ok     <= crc1_new && crc2 && !len_err;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

`default_nettype wire

@@ tb/tb_ac3_frame_crc_checker.sv @@
// ----------------------------------------------------------------------------
// Testbench for the AC-3 syncframe CRC checker
// Sends syncframes as words and predicts the verdict word of every frame with
// a bitwise CRC-16 tracker of its own. The stimulus covers well-formed frames
// with and without valid CRC words, broken frame lengths, overlong frames and
// random noise, under several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ac3_frame_crc_checker;
	import ac3fcc_pkg::*;

	// Upper bound on the running time; far beyond the slowest correct run.
	localparam int RUN_LIMIT_NS = 4_000_000;
	// Cycles allowed after the last verdict for stray output to show up.
	localparam int SETTLE_CYCLES = 10;
	// Length of the long frames, kept modest so the whole run stays short.
	localparam int LONG_FRAME_WORDS = 160;
	// Words sent in each phase of random traffic.
	localparam int unsigned RANDOM_PHASE_WORDS = 90;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      word_valid;
	logic      word_ready;
	in_word_t  word;
	logic      result_valid;
	logic      result_ready;
	out_word_t result;

	// Chance, in percent, that the sender holds back a word in a given cycle
	// and that the receiver refuses a verdict in a given cycle.
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;

	int unsigned words_sent = 0;
	int unsigned fail_count = 0;

	// Verdicts that the tracker has worked out and the block still owes us.
	out_word_t expected_verdicts[$];

	// Frame tracker state: running CRC, index of the next word, the sampled
	// frame length and the CRC1 verdict so far.
	logic [15:0] trk_crc = CRC_INIT;
	int          trk_index = 0;
	int          trk_len = 0;
	logic        trk_crc1 = 1'b1;

	ac3_frame_crc_checker DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.word_valid   (word_valid),
		.word_ready   (word_ready),
		.word         (word),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The receiver decides afresh on every falling edge whether it will take
	// a verdict word at the next rising edge.
	always @(negedge clk) begin
		result_ready <= ($urandom_range(99) >= stall_pct);
	end

	// One CRC-16 step of a byte, most significant bit first, done bit by bit
	// so that it stays independent of the table in the design.
	function automatic logic [15:0] crc16_byte_step(logic [15:0] crc, logic [7:0] b);
		logic [15:0] r;
		r = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
		end
		return r;
	endfunction

	// A word enters the CRC high byte first, as the first stream byte sits
	// in the upper half.
	function automatic logic [15:0] crc16_word_step(logic [15:0] crc, logic [15:0] w);
		return crc16_byte_step(crc16_byte_step(crc, w[15:8]), w[7:0]);
	endfunction

	// Advances the frame tracker by one accepted word and queues a verdict
	// when the word carries the last mark.
	function automatic void track_frame_word(in_word_t w);
		int        crc1_point;
		out_word_t v;
		if (trk_index == 0) begin
			// The sync word only delivers the frame length.
			trk_len = w.frame_words;
			trk_crc = CRC_INIT;
			trk_crc1 = 1'b1;
		end else begin
			trk_crc = crc16_word_step(trk_crc, w.data_word);
		end
		// CRC1 covers the first five-eighths of the frame. When that span
		// holds no words at all, CRC1 is simply left as passed.
		crc1_point = trk_len / 2 + trk_len / 8;
		if (crc1_point >= 2 && trk_index == crc1_point - 1) begin
			trk_crc1 = (trk_crc == 16'h0000);
		end
		if (!w.last) begin
			// The index sticks at the top of its range on an overlong frame.
			if (trk_index < MAX_FRAME_WORDS_DEF - 1) begin
				trk_index++;
			end
		end else begin
			v.crc1_ok = trk_crc1;
			v.crc2_ok = (trk_crc == 16'h0000);
			v.length_error = (trk_len == 0) || (trk_index != trk_len - 1);
			v.frame_ok = v.crc1_ok && v.crc2_ok && !v.length_error;
			expected_verdicts.push_back(v);
			trk_crc = CRC_INIT;
			trk_index = 0;
			trk_crc1 = 1'b1;
		end
	endfunction

	task automatic check_flag(string name, logic want, logic got);
		if (got !== want) begin
			$error("%s: expected %0b, got %0b", name, want, got);
			fail_count++;
		end
	endtask

	// Every verdict word taken by the receiver is held against the oldest
	// outstanding prediction.
	always @(posedge clk) begin : verdict_check
		out_word_t want;
		if (arst_n && result_valid && result_ready) begin
			if (expected_verdicts.size() == 0) begin
				$error("verdict word %b arrived with none outstanding", result);
				fail_count++;
			end else begin
				want = expected_verdicts.pop_front();
				check_flag("crc1_ok", want.crc1_ok, result.crc1_ok);
				check_flag("crc2_ok", want.crc2_ok, result.crc2_ok);
				check_flag("length_error", want.length_error, result.length_error);
				check_flag("frame_ok", want.frame_ok, result.frame_ok);
			end
		end
	end

	// Sends one word. It is entered and left on a falling edge. On return the
	// valid line is still high, so the caller either sends the next word at
	// once or lowers valid through wait_verdicts_drained.
	task automatic push_word(in_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			word_valid <= 1'b0;
			@(negedge clk);
		end
		word <= w;
		word_valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (!word_ready);
		track_frame_word(w);
		words_sent++;
		@(negedge clk);
	endtask

	// The sender stops and waits until every predicted verdict has come out.
	task automatic wait_verdicts_drained();
		word_valid <= 1'b0;
		while (expected_verdicts.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// Sends one frame of n_words words that announces len_field as its length.
	// Where asked, the word at the CRC1 point and the last word are replaced
	// by the running CRC, which brings the register back to zero there.
	task automatic send_frame(int len_field, int n_words, bit fix_crc1, bit fix_crc2);
		in_word_t    w;
		logic [15:0] crc;
		int          crc1_point;
		crc = CRC_INIT;
		crc1_point = len_field / 2 + len_field / 8;
		for (int i = 0; i < n_words; i++) begin
			w.data_word = 16'($urandom_range(16'hFFFF));
			// Only the first word's length counts; the rest carry noise there.
			w.frame_words = (i == 0) ? 12'(len_field) : 12'($urandom_range(12'hFFF));
			w.last = (i == n_words - 1);
			if (i > 0 && ((fix_crc1 && i == crc1_point - 1) || (fix_crc2 && i == n_words - 1))) begin
				w.data_word = crc;
			end
			if (i > 0) begin
				crc = crc16_word_step(crc, w.data_word);
			end
			push_word(w);
		end
	endtask

	// Words with random contents and a scattered last mark.
	task automatic send_noise(int count);
		in_word_t w;
		for (int i = 0; i < count; i++) begin
			w.data_word = 16'($urandom_range(16'hFFFF));
			w.frame_words = 12'($urandom_range(12'hFFF));
			w.last = ($urandom_range(5) == 0);
			push_word(w);
		end
	endtask

	// Short frames at the corners: a one-word frame at full data, a zero and
	// an oversize length on a lone word, frames whose CRC1 span is empty, a
	// good frame of eight words, and a last mark that comes before the CRC1
	// point.
	task automatic test_directed_frames();
		push_word('{data_word: 16'hFFFF, frame_words: 12'd1, last: 1'b1});
		push_word('{data_word: 16'h0000, frame_words: 12'd0, last: 1'b1});
		push_word('{data_word: 16'h0B77, frame_words: 12'hFFF, last: 1'b1});
		send_frame(2, 2, 1'b1, 1'b1);
		send_frame(3, 3, 1'b1, 1'b1);
		send_frame(8, 8, 1'b1, 1'b1);
		send_frame(8, 3, 1'b1, 1'b1);
	endtask

	// A long frame with both CRC words in place, the same length run two
	// words past its announced end, and an announced length beyond the
	// index range.
	task automatic test_long_frames();
		send_frame(LONG_FRAME_WORDS, LONG_FRAME_WORDS, 1'b1, 1'b1);
		send_frame(LONG_FRAME_WORDS, LONG_FRAME_WORDS + 2, 1'b1, 1'b1);
		send_frame(MAX_FRAME_WORDS_DEF + 52, 20, 1'b1, 1'b1);
	endtask

	// Mostly well-formed frames, most of them with correct CRC words, mixed
	// with frames of the wrong length and bursts of noise.
	task automatic test_random_traffic(int unsigned word_count);
		int unsigned start;
		int unsigned pick;
		int          len;
		int          n;
		start = words_sent;
		while (words_sent - start < word_count) begin
			pick = $urandom_range(99);
			len = ($urandom_range(9) == 0) ? $urandom_range(200, 25) : $urandom_range(24, 1);
			if (pick < 70) begin
				send_frame(len, len, $urandom_range(3) != 0, $urandom_range(3) != 0);
			end else if (pick < 85) begin
				if ($urandom_range(3) == 0) begin
					len = $urandom_range(12'hFFF);
					n = $urandom_range(30, 1);
				end else begin
					n = len + $urandom_range(6) - 3;
					if (n < 1) begin
						n = 1;
					end
				end
				send_frame(len, n, $urandom_range(1), $urandom_range(1));
			end else begin
				send_noise($urandom_range(10, 1));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		word_valid = 1'b0;
		word = '0;
		result_ready = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_frames();
		wait_verdicts_drained();
		test_long_frames();
		wait_verdicts_drained();

		// Four phases of random traffic, each drained before the next so the
		// sender also sits out whole stretches with nothing in flight.
		send_idle_pct = 0;
		stall_pct = 0;
		test_random_traffic(RANDOM_PHASE_WORDS);
		wait_verdicts_drained();
		send_idle_pct = 51;
		stall_pct = 0;
		test_random_traffic(RANDOM_PHASE_WORDS);
		wait_verdicts_drained();
		send_idle_pct = 0;
		stall_pct = 51;
		test_random_traffic(RANDOM_PHASE_WORDS);
		wait_verdicts_drained();
		send_idle_pct = 8;
		stall_pct = 8;
		test_random_traffic(RANDOM_PHASE_WORDS);
		wait_verdicts_drained();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("** ac3_frame_crc_checker: PASSED **");
		end else begin
			$display("** ac3_frame_crc_checker: FAILED **");
		end
		$finish;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("** ac3_frame_crc_checker: FAILED **");
		$finish;
	end

endmodule
